### rtl/fpst_pkg.sv
// ----------------------------------------------------------------------------
// fpst_pkg
// Shared types and constants for the binary indexed prefix-sum table.
// ----------------------------------------------------------------------------
package fpst_pkg;

	localparam int IDX_W = 11;   // index, low index and size register width
	localparam int POS_W = 12;   // node walker width, holds an upward step past size
	localparam int VAL_W = 32;   // partial sum and value width

	localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_PREFIX = 2'd1,
		ACT_RANGE  = 2'd2
	} action_t;

	typedef struct packed {
		logic [VAL_W-1:0] sum;
		logic             clamped;
	} result_t;

endpackage

### rtl/fpst_mem.sv
// ----------------------------------------------------------------------------
// fpst_mem
// Partial-sum storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fpst_mem
	import fpst_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [VAL_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/fpst_ctrl.sv
// ----------------------------------------------------------------------------
// fpst_ctrl
// Tree walker: clears the table after reset, runs point adds as
// read-modify-write walks and prefix/range queries as accumulate walks.
// ----------------------------------------------------------------------------
module fpst_ctrl
	import fpst_pkg::*;
#(
	parameter int MAX_SIZE = 1024,
	parameter int AW       = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [IDX_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              in_action,
	input  logic [IDX_W-1:0]        in_index,
	input  logic [IDX_W-1:0]        in_low,
	input  logic signed [VAL_W-1:0] in_value,
	output logic                    res_valid,
	input  logic                    res_ready,
	output result_t                 res,
	output logic                    mem_we,
	output logic [AW-1:0]           mem_waddr,
	output logic [VAL_W-1:0]        mem_wdata,
	output logic                    mem_re,
	output logic [AW-1:0]           mem_raddr,
	input  logic [VAL_W-1:0]        mem_rdata
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD,
		ST_WALK,
		ST_FIN
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_q;
	logic [IDX_W-1:0] size_q;
	logic [POS_W-1:0] pos_q;
	logic [IDX_W-1:0] lo_q;
	logic             phase_q;
	logic             flag_q;
	logic [VAL_W-1:0] acc_q;
	logic [VAL_W-1:0] val_q;

	logic [IDX_W-1:0] eff_n;
	logic [IDX_W-1:0] hi_c;
	logic [IDX_W-1:0] below;
	logic [IDX_W-1:0] lo_c;
	logic [IDX_W-1:0] lo_sel;
	logic             flag_in;
	logic [POS_W-1:0] st_pos;
	logic             st_phase;
	logic             add_go;
	logic [POS_W-1:0] lowbit;
	logic [POS_W-1:0] up_nxt;
	logic [POS_W-1:0] dn_nxt;
	logic             up_ok;
	logic             lo_start;
	logic [VAL_W-1:0] acc_nxt;

	// map a 1-based node number to a memory address
	function automatic logic [AW-1:0] to_addr(input logic [POS_W-1:0] p);
		logic [AW+POS_W-1:0] e;
		e = {{AW{1'b0}}, p - 1'b1};
		return e[AW-1:0];
	endfunction

	// effective size and bound clamping
	always_comb begin
		eff_n    = (32'(size_q) > 32'(MAX_SIZE)) ? IDX_W'(MAX_SIZE) : size_q;
		hi_c     = (in_index > eff_n) ? eff_n : in_index;
		below    = (in_low == '0) ? '0 : in_low - 1'b1;
		lo_c     = (below > eff_n) ? eff_n : below;
		lo_sel   = (action_t'(in_action) == ACT_RANGE) ? lo_c : '0;
		flag_in  = (in_index > eff_n) ||
			((action_t'(in_action) == ACT_RANGE) && (below > eff_n));
		st_pos   = (hi_c == '0) ? {1'b0, lo_sel} : {1'b0, hi_c};
		st_phase = (hi_c == '0);
		add_go   = (in_index != '0) && (in_index <= eff_n);
	end

	// walk steps: up by lowest set bit, down by clearing it
	always_comb begin
		lowbit   = pos_q & (~pos_q + 1'b1);
		up_nxt   = pos_q + lowbit;
		dn_nxt   = pos_q & (pos_q - 1'b1);
		up_ok    = (up_nxt <= {1'b0, eff_n});
		lo_start = !phase_q && (lo_q != '0);
		acc_nxt  = phase_q ? acc_q - mem_rdata : acc_q + mem_rdata;
	end

	// memory requests
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = to_addr(pos_q);
		mem_wdata = mem_rdata + val_q;
		mem_re    = 1'b0;
		mem_raddr = to_addr(st_pos);
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				if (action_t'(in_action) == ACT_ADD) begin
					mem_raddr = to_addr({1'b0, in_index});
					mem_re    = in_valid && add_go;
				end else begin
					mem_re = in_valid && (st_pos != '0);
				end
			end
			ST_ADD: begin
				mem_we    = 1'b1;
				mem_raddr = to_addr(up_nxt);
				mem_re    = up_ok;
			end
			ST_WALK: begin
				mem_raddr = (dn_nxt != '0) ? to_addr(dn_nxt) : to_addr({1'b0, lo_q});
				mem_re    = (dn_nxt != '0) || lo_start;
			end
			ST_FIN: begin
				mem_re = 1'b0;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign res_valid   = (state_q == ST_FIN);
	assign res.sum     = acc_q;
	assign res.clamped = flag_q;

	// size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			phase_q <= 1'b0;
			flag_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						val_q   <= in_value;
						acc_q   <= '0;
						flag_q  <= flag_in;
						lo_q    <= lo_sel;
						phase_q <= st_phase;
						unique case (action_t'(in_action))
							ACT_ADD: begin
								pos_q <= {1'b0, in_index};
								if (add_go) begin
									state_q <= ST_ADD;
								end
							end
							ACT_PREFIX, ACT_RANGE: begin
								pos_q   <= st_pos;
								state_q <= (st_pos != '0) ? ST_WALK : ST_FIN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ADD: begin
					// write back this node, advance to the next one up
					pos_q <= up_nxt;
					if (!up_ok) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					acc_q <= acc_nxt;
					if (dn_nxt != '0) begin
						pos_q <= dn_nxt;
					end else if (lo_start) begin
						pos_q   <= {1'b0, lo_q};
						phase_q <= 1'b1;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold the result until the output register frees up
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/fenwick_prefix_sum_table_unit.sv
// A point add reads and writes back each node on its path up (up to 11 at size 1024);
// a query reads one table word per node on its walks down (up to 20 for a range query).
// Throughput: one word at a time; a new input word is accepted only while the walker is idle.
// Reset: the size register returns to 1024 and a clearing pass writes zero to all
// MAX_SIZE entries, one per cycle, before the first input word is accepted.
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table_unit
// Binary indexed tree of 32-bit wrapping partial sums with point add,
// prefix query and range query, and a registered result stage.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table_unit
	import fpst_pkg::*;
#(
	parameter int MAX_SIZE = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_wdata,      // size_in_use
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [55:0]      s_axis_tdata,   // index[10:0], low_index[21:11], value[53:22]
	input  logic [1:0]       s_axis_tuser,   // action[1:0]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // sum[31:0]
	output logic             m_axis_tuser    // clamped[0]
);

	localparam int AW = $clog2(MAX_SIZE);

	logic             res_valid;
	logic             res_ready;
	result_t          res;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [VAL_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [VAL_W-1:0] mem_rdata;
	logic             out_valid_q;
	result_t          out_q;

	fpst_ctrl #(
		.MAX_SIZE (MAX_SIZE),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_index  (s_axis_tdata[10:0]),
		.in_low    (s_axis_tdata[21:11]),
		.in_value  (s_axis_tdata[53:22]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	fpst_mem #(
		.DEPTH (MAX_SIZE),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: free when empty or being drained
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.sum;
	assign m_axis_tuser  = out_q.clamped;

endmodule
